// File: sv/kps_pkg.sv
`default_nettype none

package kps_pkg;

    localparam int PinWidth    = 8;
    localparam int ColIdxWidth = 3;
    localparam int NibbleShift = 4;
    localparam int OutWidth    = 24;

    localparam logic CfgColumnMask = 1'b0;
    localparam logic CfgRowMask    = 1'b1;

    localparam logic [PinWidth-1:0] ColumnMaskReset = 8'd15;
    localparam logic [PinWidth-1:0] RowMaskReset    = 8'd240;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_SCAN    = 3'b010,
        PH_RELEASE = 3'b100
    } phase_t;

    typedef struct packed {
        logic                   found;
        logic [ColIdxWidth-1:0] idx;
    } lowest_t;

    typedef struct packed {
        logic                busy_res;
        logic                scan_error;
        logic                key_saved;
        logic [PinWidth-1:0] key_code;
        logic [PinWidth-1:0] column_drive;
    } result_t;

    function automatic lowest_t lowest_one(input logic [PinWidth-1:0] bits);
        lowest_t res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = PinWidth - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                res.found = 1'b1;
                res.idx   = ColIdxWidth'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/kps_core.sv
`default_nettype none

module kps_core #(
    parameter int PIN_COUNT = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [kps_pkg::PinWidth-1:0]  cfg_data,
    input  wire logic                          step,
    input  wire logic [kps_pkg::PinWidth-1:0]  row_levels,
    output kps_pkg::result_t                   result
);

    localparam logic [kps_pkg::PinWidth-1:0] PinMask =
        kps_pkg::PinWidth'((16'd1 << PIN_COUNT) - 16'd1);

    kps_pkg::phase_t                        phase_reg, phase_next;
    logic [kps_pkg::ColIdxWidth-1:0]        scan_column_reg, scan_column_next;
    logic [kps_pkg::PinWidth-1:0]           pending_code_reg, pending_code_next;
    logic [kps_pkg::PinWidth-1:0]           current_code_reg, current_code_next;
    logic [kps_pkg::PinWidth-1:0]           previous_rows_reg, previous_rows_next;
    logic [kps_pkg::PinWidth-1:0]           column_mask_reg, row_mask_reg;

    logic [kps_pkg::PinWidth-1:0]           rmask, rows, all_cols, later_cols;
    logic [kps_pkg::PinWidth-1:0]           drive;
    logic                                   saved, err;
    kps_pkg::lowest_t                       first_col, next_col, first_row;

    always_comb
    begin
        rmask      = row_mask_reg & PinMask;
        rows       = row_levels & rmask;
        all_cols   = column_mask_reg & PinMask;
        later_cols = all_cols & (8'hFF << ({1'b0, scan_column_reg} + 4'd1));
        first_col  = kps_pkg::lowest_one(all_cols);
        next_col   = kps_pkg::lowest_one(later_cols);
        first_row  = kps_pkg::lowest_one(rows);

        phase_next         = phase_reg;
        scan_column_next   = scan_column_reg;
        pending_code_next  = pending_code_reg;
        current_code_next  = current_code_reg;
        previous_rows_next = rows;
        drive              = all_cols;
        saved              = 1'b0;
        err                = 1'b0;

        unique case (phase_reg)
            kps_pkg::PH_SCAN:
            begin
                if (rows != '0)
                begin
                    pending_code_next = {1'b0, scan_column_reg, 1'b0, first_row.idx};
                    phase_next        = kps_pkg::PH_RELEASE;
                end
                else if (next_col.found)
                begin
                    scan_column_next = next_col.idx;
                    drive            = 8'd1 << next_col.idx;
                end
                else
                begin
                    err                = 1'b1;
                    phase_next         = kps_pkg::PH_IDLE;
                    previous_rows_next = rmask;
                end
            end
            kps_pkg::PH_RELEASE:
            begin
                if ((previous_rows_reg & ~rows & rmask) != '0)
                begin
                    current_code_next = pending_code_reg;
                    saved             = 1'b1;
                    phase_next        = kps_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = kps_pkg::PH_IDLE;
                if ((rows & ~previous_rows_reg & rmask) != '0)
                begin
                    if (first_col.found)
                    begin
                        scan_column_next = first_col.idx;
                        phase_next       = kps_pkg::PH_SCAN;
                        drive            = 8'd1 << first_col.idx;
                    end
                    else
                    begin
                        err                = 1'b1;
                        previous_rows_next = rmask;
                    end
                end
            end
        endcase

        result.column_drive = drive;
        result.key_code     = current_code_next;
        result.key_saved    = saved;
        result.scan_error   = err;
        result.busy_res     = (phase_next == kps_pkg::PH_SCAN) ||
                              (phase_next == kps_pkg::PH_RELEASE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= kps_pkg::PH_IDLE;
            scan_column_reg   <= '0;
            pending_code_reg  <= '0;
            current_code_reg  <= '0;
            previous_rows_reg <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            scan_column_reg   <= scan_column_next;
            pending_code_reg  <= pending_code_next;
            current_code_reg  <= current_code_next;
            previous_rows_reg <= previous_rows_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_mask_reg <= kps_pkg::ColumnMaskReset;
            row_mask_reg    <= kps_pkg::RowMaskReset;
        end
        else if (cfg_we)
        begin
            if (cfg_index == kps_pkg::CfgColumnMask)
            begin
                column_mask_reg <= cfg_data;
            end
            else
            begin
                row_mask_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/matrix_keypad_scanner.sv
// an input transfer passes the input register, then the result register, which drives m_tvalid;
// a stalled result (m_tvalid high, m_tready low) holds the next sample in the input register
// throughput: one row sample per cycle, sustained while m_tready stays high
// the state update and result logic sit between the two registers
// reset: asynchronous, active low; idle phase, codes cleared, masks to 15 and 240
`default_nettype none

module matrix_keypad_scanner #(
    parameter int PIN_COUNT = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [kps_pkg::PinWidth-1:0]   cfg_data,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [kps_pkg::PinWidth-1:0]   s_tdata,  // [7:0] row_levels
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] column_drive, [15:8] key_code, [16] key_saved, [17] scan_error,
    // [18] busy_res, [23:19] zero
    output      logic [kps_pkg::OutWidth-1:0]   m_tdata
);

    logic                          in_valid_reg;
    logic [kps_pkg::PinWidth-1:0]  in_data_reg;
    logic                          out_valid_reg;
    kps_pkg::result_t              out_data_reg;
    kps_pkg::result_t              result;
    logic                          advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(kps_pkg::OutWidth - $bits(kps_pkg::result_t)){1'b0}}, out_data_reg};

    kps_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .step       (advance),
        .row_levels (in_data_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

// File: sv/kps_checker.sv
`default_nettype none

module kps_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [kps_pkg::OutWidth-1:0]   m_tdata
);

    // stalled result transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a release commit and a failed scan never share a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[16] && m_tdata[17]))
        else $error("key_saved with scan_error");

    // both a commit and a failed scan leave the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[16] || m_tdata[17]) |-> !m_tdata[18])
        else $error("busy after commit or error");

    // key code only moves on a commit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready ##1 m_tvalid && !m_tdata[16]
            |-> m_tdata[15:8] == $past(m_tdata[15:8]))
        else $error("key code changed without commit");

endmodule

bind matrix_keypad_scanner kps_checker u_kps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CycleLimit = 300000;
    localparam int HoldOffCycles = 400;

    // {column mask, row mask} per random segment; zero entries get random masks
    localparam logic [15:0] SegMasks [12] = '{
        16'h0FF0, 16'hFFFF, 16'h0000, 16'h8001, 16'hFF00, 16'h0000,
        16'h01FF, 16'hF00F, 16'h0000, 16'hFF80, 16'h0FF0, 16'h0000
    };

    typedef enum logic {STEP_ROWS, STEP_CFG} step_kind_t;

    typedef struct {
        step_kind_t       kind;
        logic             cfg_sel;
        logic [7:0]       value;
        logic             typed;
        kps_pkg::result_t want;
    } dir_step_t;

    // want: busy_res, scan_error, key_saved, key_code, column_drive
    dir_step_t dir_steps [28] = '{
        '{STEP_ROWS, 1'b0, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 8'h0F}},
        '{STEP_ROWS, 1'b0, 8'h10, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h00, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h20, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h20, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h00, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h0F, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h80, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h00, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h00, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h00, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h15, 8'h0F}},
        '{STEP_ROWS, 1'b0, 8'hF0, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h00, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'hFF, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'hF0, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h70, 1'b0, '0},
        '{STEP_CFG, kps_pkg::CfgColumnMask, 8'h00, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h00, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h10, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h04, 8'h00}},
        '{STEP_CFG, kps_pkg::CfgColumnMask, 8'hFF, 1'b0, '0},
        '{STEP_CFG, kps_pkg::CfgRowMask, 8'hFF, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h01, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h00, 1'b0, '0},
        '{STEP_CFG, kps_pkg::CfgColumnMask, 8'h80, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h00, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h80, 1'b0, '0},
        '{STEP_ROWS, 1'b0, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b1, 8'h77, 8'h80}}
    };

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic                         cfg_index = 1'b0;
    logic [kps_pkg::PinWidth-1:0] cfg_data = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [kps_pkg::PinWidth-1:0] s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [kps_pkg::OutWidth-1:0] m_tdata;

    // predictor state
    logic [7:0]      col_mask_q = kps_pkg::ColumnMaskReset;
    logic [7:0]      row_mask_q = kps_pkg::RowMaskReset;
    kps_pkg::phase_t kp_phase = kps_pkg::PH_IDLE;
    logic [2:0]      scan_col_q = '0;
    logic [7:0]      pending_q = '0;
    logic [7:0]      current_q = '0;
    logic [7:0]      prev_rows_q = '0;
    logic [7:0]      drive_q = kps_pkg::ColumnMaskReset;

    kps_pkg::result_t scan_results_due [$];
    int               mismatch_count = 0;
    int               cycle_count = 0;
    int               send_idle_pct = 0;
    int               ready_stall_pct = 0;
    int               hold_off_len = 0;
    logic             item_typed = 1'b0;
    kps_pkg::result_t item_want = '0;

    matrix_keypad_scanner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic int first_set(input logic [7:0] bits, input int from);
        for (int i = from; i < 8; i++)
        begin
            if (bits[i])
                return i;
        end
        return 8;
    endfunction

    function automatic logic [2:0] pick_pin(input logic [7:0] mask);
        logic [2:0] p;
        p = 3'($urandom_range(7));
        if (mask != '0 && $urandom_range(6) != 0)
        begin
            while (!mask[p])
                p = 3'($urandom_range(7));
        end
        return p;
    endfunction

    task automatic predict_scan(input logic [7:0] sample, output kps_pkg::result_t res);
        logic [7:0] rows;
        logic [7:0] drive;
        logic [7:0] next_prev;
        logic       saved;
        logic       err;
        int         c;
        rows      = sample & row_mask_q;
        drive     = col_mask_q;
        next_prev = rows;
        saved     = 1'b0;
        err       = 1'b0;
        case (kp_phase)
            kps_pkg::PH_SCAN:
            begin
                if (rows != '0)
                begin
                    pending_q = (8'(scan_col_q) << kps_pkg::NibbleShift)
                                | 8'(first_set(rows, 0));
                    kp_phase  = kps_pkg::PH_RELEASE;
                end
                else
                begin
                    c = first_set(col_mask_q, int'(scan_col_q) + 1);
                    if (c < 8)
                    begin
                        scan_col_q = 3'(c);
                        drive      = 8'(1) << c;
                    end
                    else
                    begin
                        err       = 1'b1;
                        kp_phase  = kps_pkg::PH_IDLE;
                        next_prev = row_mask_q;
                    end
                end
            end
            kps_pkg::PH_RELEASE:
            begin
                if ((prev_rows_q & ~rows & row_mask_q) != '0)
                begin
                    current_q = pending_q;
                    saved     = 1'b1;
                    kp_phase  = kps_pkg::PH_IDLE;
                end
            end
            default:
            begin
                kp_phase = kps_pkg::PH_IDLE;
                if ((rows & ~prev_rows_q & row_mask_q) != '0)
                begin
                    c = first_set(col_mask_q, 0);
                    if (c < 8)
                    begin
                        scan_col_q = 3'(c);
                        kp_phase   = kps_pkg::PH_SCAN;
                        drive      = 8'(1) << c;
                    end
                    else
                    begin
                        err       = 1'b1;
                        next_prev = row_mask_q;
                    end
                end
            end
        endcase
        prev_rows_q      = next_prev;
        drive_q          = drive;
        res.column_drive = drive;
        res.key_code     = current_q;
        res.key_saved    = saved;
        res.scan_error   = err;
        res.busy_res     = (kp_phase != kps_pkg::PH_IDLE);
    endtask

    // config, result check and prediction in one place so queue order is fixed
    always @(posedge clk)
    begin
        kps_pkg::result_t got;
        kps_pkg::result_t want;
        kps_pkg::result_t res;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == kps_pkg::CfgColumnMask)
                    col_mask_q = cfg_data;
                else
                    row_mask_q = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                got = kps_pkg::result_t'(m_tdata[$bits(kps_pkg::result_t)-1:0]);
                if (scan_results_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transfer: %h", m_tdata);
                end
                else
                begin
                    want = scan_results_due.pop_front();
                    if (got.column_drive !== want.column_drive
                        || got.key_code !== want.key_code
                        || got.key_saved !== want.key_saved
                        || got.scan_error !== want.scan_error
                        || got.busy_res !== want.busy_res)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected drive=%h code=%h saved=%b ",
                                      "err=%b busy=%b, got drive=%h code=%h saved=%b ",
                                      "err=%b busy=%b"},
                                     want.column_drive, want.key_code, want.key_saved,
                                     want.scan_error, want.busy_res,
                                     got.column_drive, got.key_code, got.key_saved,
                                     got.scan_error, got.busy_res);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_scan(s_tdata, res);
                scan_results_due.push_back(item_typed ? item_want : res);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_len != 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_off_len) @(negedge clk);
                hold_off_len = 0;
            end
            m_tready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    task automatic send_rows(input logic [7:0] sample, input logic typed,
                             input kps_pkg::result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= sample;
        item_typed = typed;
        item_want  = want;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (scan_results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int         seg_len;
        int         sent;
        int         hold;
        int         rel;
        int         n_keys;
        int         n_noise;
        logic [7:0] seg_cols;
        logic [7:0] seg_rows;
        logic [7:0] sample;
        logic [2:0] key_col [2];
        logic [2:0] key_row [2];

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_steps[i])
        begin
            if (dir_steps[i].kind == STEP_CFG)
            begin
                wait_all_results();
                write_reg(dir_steps[i].cfg_sel, dir_steps[i].value);
            end
            else
                send_rows(dir_steps[i].value, dir_steps[i].typed, dir_steps[i].want);
        end

        for (int seg = 0; seg < 12; seg++)
        begin
            wait_all_results();
            seg_cols = SegMasks[seg][15:8];
            seg_rows = SegMasks[seg][7:0];
            if (SegMasks[seg] == '0)
            begin
                seg_cols = 8'($urandom);
                seg_rows = 8'($urandom);
            end
            write_reg(kps_pkg::CfgColumnMask, seg_cols);
            write_reg(kps_pkg::CfgRowMask, seg_rows);
            case (seg / 3)
                0:
                begin
                    send_idle_pct   = 0;
                    ready_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct   = 75;
                    ready_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct   = 0;
                    ready_stall_pct = 75;
                end
                default:
                begin
                    send_idle_pct   = 20;
                    ready_stall_pct = 20;
                end
            endcase
            if (seg == 6)
                hold_off_len = HoldOffCycles;
            seg_len = (seg_rows == '0) ? 20 : 130;
            sent = 0;
            while (sent < seg_len)
            begin
                if ($urandom_range(99) < 80)
                begin
                    // key press: held, then released; sometimes two keys at once
                    n_keys = ($urandom_range(9) == 0) ? 2 : 1;
                    for (int k = 0; k < 2; k++)
                    begin
                        key_col[k] = pick_pin(col_mask_q);
                        key_row[k] = pick_pin(row_mask_q);
                    end
                    hold = $urandom_range(2, 14);
                    rel  = $urandom_range(1, 5);
                    for (int j = 0; j < hold + rel; j++)
                    begin
                        sample = '0;
                        if (j < hold)
                        begin
                            for (int k = 0; k < n_keys; k++)
                            begin
                                if (drive_q[key_col[k]])
                                    sample[key_row[k]] = 1'b1;
                            end
                        end
                        if ($urandom_range(3) == 0)
                            sample = sample | (8'($urandom) & ~row_mask_q);
                        send_rows(sample, 1'b0, '0);
                    end
                    sent += hold + rel;
                end
                else
                begin
                    n_noise = $urandom_range(1, 6);
                    for (int j = 0; j < n_noise; j++)
                        send_rows(8'($urandom), 1'b0, '0);
                    sent += n_noise;
                end
            end
        end

        wait_all_results();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
